/* design/bcv_pkg.sv */
// shared constants, types and helpers for the block chain validator
package bcv_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int MAX_PADS     = 2;
    localparam int OFFSET_BITS  = 48;

    localparam int LIMIT_W  = 17;
    localparam int SIZE_W   = 31;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 4;
    localparam int IDX_W    = 4;
    localparam int PADS_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;
    localparam int M_DATA_W   = 168;

    localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RESET = LIMIT_W'(100000);
    localparam logic [7:0] PAD_VALUE = 8'h6b;
    localparam logic [WORD_W-1:0] ORIG_CAP = 32'h7fffffff;
    localparam logic [WORD_W-1:0] DECL_CAP = 32'h7ffffffd;
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HEADER_BYTES - 1);
    localparam logic [PADS_W-1:0] PAD_MAX = PADS_W'(MAX_PADS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 8'd1;

    // result kinds
    localparam logic KIND_DESC    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_MAGIC  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ALIGN  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_LARGE  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SUM    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_MARKER = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TRUNC  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_MANY   = 4'd8;

    typedef struct packed {
        logic                   kind;
        logic                   last;
        logic [STATUS_W-1:0]    status;
        logic [WORD_W-1:0]      sum_field;
        logic [SIZE_W-1:0]      payload_size;
        logic [SIZE_W-1:0]      original_size;
        logic [OFFSET_BITS-1:0] block_offset;
        logic [LIMIT_W-1:0]     block_number;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4d;
            2'd1:    b = 8'h49;
            2'd2:    b = 8'h31;
            default: b = 8'h30;
        endcase
        return b;
    endfunction

endpackage

/* design/block_chain_validator.sv */
// block chain validator top level: byte stream in, descriptors and verdict out
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tlast carry the container, one byte per
//   transaction (s_tdata[7:0] = data_byte, s_tlast = end_of_input).
//   m_* carries results: a descriptor at each good marker byte and one
//   verdict on the final byte (m_tuser = result_kind, m_tlast = last_result).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write block_limit (index 0) and
//   base_offset (index 1); cfg_ready is always high.
// Throughput: one byte per cycle; the header checks, counters and the
//   checksum bound (original*255 as a shift and subtract) settle in the
//   cycle the byte is accepted.
// Output: each result is written into the output buffer on the edge that accepts its byte.
// Stall: results go through a two-entry output buffer, so bytes keep flowing
//   while one result waits; s_tready drops only when both entries are full.
// Reset: aresetn clears the chain state and output buffer, sets block_limit
//   to 100000 and base_offset to 0. After each verdict the chain state
//   clears and the next container may follow directly.
module block_chain_validator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // data_byte[7:0]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // block_number[16:0], block_offset[64:17], original_size[95:65],
    // payload_size[126:96], sum_field[158:127], status[162:159], zero[167:163]
    output logic [bcv_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,    // result_kind[0]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcv_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MARKER,
        PH_PAYLOAD,
        PH_GAP,
        PH_SINK
    } phase_t;

    localparam int OB = bcv_pkg::OFFSET_BITS;
    localparam int WW = bcv_pkg::WORD_W;
    localparam int LW = bcv_pkg::LIMIT_W;
    localparam int SW = bcv_pkg::STATUS_W;
    localparam int IW = bcv_pkg::IDX_W;
    localparam int PW = bcv_pkg::PADS_W;
    localparam int ZW = bcv_pkg::SIZE_W;

    // configuration
    logic [LW-1:0] block_limit_reg;
    logic [OB-1:0] base_offset_reg;

    // chain state
    phase_t        phase_reg, phase_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [IW-1:0] hidx_reg, hidx_next;
    logic [OB-1:0] hstart_reg, hstart_next;
    logic [WW-1:0] hsum_reg, hsum_next;
    logic [WW-1:0] horig_reg, horig_next;
    logic [WW-1:0] hdecl_reg, hdecl_next;
    logic [WW-1:0] left_reg, left_next;
    logic [PW-1:0] pads_reg, pads_next;
    logic [LW-1:0] blocks_reg, blocks_next;
    logic [SW-1:0] ferr_reg, ferr_next;

    // output buffer
    bcv_pkg::result_t q0_reg, q1_reg;
    logic             q0v_reg, q1v_reg;

    logic             in_acc, out_pop, push;
    logic             emit_desc, begin_hdr, do_hdr;
    logic [IW-1:0]    idx_cur;
    logic [WW-1:0]    sum_cur, orig_cur, decl_cur;
    logic [WW+7:0]    sum_bound;
    logic [SW-1:0]    v_status;
    logic [LW-1:0]    v_count;
    bcv_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q1v_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_pop   = q0v_reg && m_tready;

    // checksum bound from the fully held uncompressed size
    assign sum_bound = {horig_reg, 8'h00} - {8'h00, horig_reg};

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg + OB'(1);
        hidx_next   = hidx_reg;
        hstart_next = hstart_reg;
        hsum_next   = hsum_reg;
        horig_next  = horig_reg;
        hdecl_next  = hdecl_reg;
        left_next   = left_reg;
        pads_next   = pads_reg;
        blocks_next = blocks_reg;
        ferr_next   = ferr_reg;
        emit_desc   = 1'b0;
        begin_hdr   = 1'b0;
        do_hdr      = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                if (hidx_reg == '0) begin
                    begin_hdr = 1'b1;
                end else begin
                    do_hdr = 1'b1;
                end
            end
            PH_MARKER: begin
                if (s_tdata != 8'h00) begin
                    ferr_next  = bcv_pkg::ST_MARKER;
                    phase_next = PH_SINK;
                end else begin
                    blocks_next = blocks_reg + LW'(1);
                    left_next   = hdecl_reg + WW'(1);
                    phase_next  = PH_PAYLOAD;
                    emit_desc   = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                left_next = left_reg - WW'(1);
                if (left_reg == WW'(1)) begin
                    phase_next = PH_GAP;
                    pads_next  = '0;
                end
            end
            PH_GAP: begin
                if (s_tdata == bcv_pkg::PAD_VALUE && pads_reg < bcv_pkg::PAD_MAX) begin
                    pads_next = pads_reg + PW'(1);
                end else begin
                    begin_hdr = 1'b1;
                end
            end
            default: begin
            end
        endcase

        idx_cur  = begin_hdr ? '0 : hidx_reg;
        sum_cur  = begin_hdr ? '0 : hsum_reg;
        orig_cur = begin_hdr ? '0 : horig_reg;
        decl_cur = begin_hdr ? '0 : hdecl_reg;

        if (begin_hdr) begin
            phase_next  = PH_HEADER;
            hidx_next   = '0;
            hstart_next = pos_reg;
            hsum_next   = '0;
            horig_next  = '0;
            hdecl_next  = '0;
            if (pos_reg[0]) begin
                ferr_next  = bcv_pkg::ST_ALIGN;
                phase_next = PH_SINK;
            end else if (blocks_reg >= block_limit_reg) begin
                ferr_next  = bcv_pkg::ST_MANY;
                phase_next = PH_SINK;
            end else begin
                do_hdr = 1'b1;
            end
        end

        if (do_hdr) begin
            if (idx_cur < IW'(4) && s_tdata != bcv_pkg::magic_byte(idx_cur[1:0])) begin
                ferr_next  = bcv_pkg::ST_MAGIC;
                phase_next = PH_SINK;
            end else begin
                if (idx_cur >= IW'(4) && idx_cur < IW'(8)) begin
                    sum_cur = {sum_cur[WW-9:0], s_tdata};
                end else if (idx_cur >= IW'(8) && idx_cur < IW'(12)) begin
                    orig_cur = {orig_cur[WW-9:0], s_tdata};
                end else if (idx_cur >= IW'(12)) begin
                    decl_cur = {decl_cur[WW-9:0], s_tdata};
                end
                hsum_next  = sum_cur;
                horig_next = orig_cur;
                hdecl_next = decl_cur;
                hidx_next  = idx_cur + IW'(1);
                if (idx_cur == bcv_pkg::HDR_LAST) begin
                    if (orig_cur == '0 || decl_cur == '0) begin
                        ferr_next  = bcv_pkg::ST_ZERO;
                        phase_next = PH_SINK;
                    end else if (orig_cur > bcv_pkg::ORIG_CAP ||
                                 decl_cur > bcv_pkg::DECL_CAP) begin
                        ferr_next  = bcv_pkg::ST_LARGE;
                        phase_next = PH_SINK;
                    end else if ({8'h00, sum_cur} > sum_bound) begin
                        ferr_next  = bcv_pkg::ST_SUM;
                        phase_next = PH_SINK;
                    end else begin
                        phase_next = PH_MARKER;
                    end
                end
            end
        end

        // verdict from the state after this byte
        v_status = ferr_next;
        v_count  = blocks_next;
        if (ferr_next == bcv_pkg::ST_OK) begin
            if (phase_next == PH_PAYLOAD) begin
                v_status = bcv_pkg::ST_TRUNC;
                v_count  = blocks_next - LW'(1);
            end else if (phase_next != PH_GAP) begin
                v_status = bcv_pkg::ST_TRUNC;
            end
        end

        if (s_tlast) begin
            res.kind          = bcv_pkg::KIND_VERDICT;
            res.last          = 1'b1;
            res.status        = v_status;
            res.sum_field     = '0;
            res.payload_size  = '0;
            res.original_size = '0;
            res.block_offset  = '0;
            res.block_number  = v_count;
        end else begin
            res.kind          = bcv_pkg::KIND_DESC;
            res.last          = 1'b0;
            res.status        = bcv_pkg::ST_OK;
            res.sum_field     = hsum_reg;
            res.payload_size  = hdecl_reg[ZW-1:0] + ZW'(2);
            res.original_size = horig_reg[ZW-1:0];
            res.block_offset  = base_offset_reg + hstart_reg;
            res.block_number  = blocks_next;
        end

        // chain clears after the verdict
        if (s_tlast) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            hidx_next   = '0;
            hstart_next = '0;
            hsum_next   = '0;
            horig_next  = '0;
            hdecl_next  = '0;
            left_next   = '0;
            pads_next   = '0;
            blocks_next = '0;
            ferr_next   = bcv_pkg::ST_OK;
        end
    end

    assign push = in_acc && (s_tlast || emit_desc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_limit_reg <= bcv_pkg::BLOCK_LIMIT_RESET;
            base_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == bcv_pkg::CFG_BLOCK_LIMIT) begin
                block_limit_reg <= cfg_data[LW-1:0];
            end else if (cfg_index == bcv_pkg::CFG_BASE_OFFSET) begin
                base_offset_reg <= cfg_data[OB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            hidx_reg   <= '0;
            hstart_reg <= '0;
            hsum_reg   <= '0;
            horig_reg  <= '0;
            hdecl_reg  <= '0;
            left_reg   <= '0;
            pads_reg   <= '0;
            blocks_reg <= '0;
            ferr_reg   <= bcv_pkg::ST_OK;
        end else if (in_acc) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hidx_reg   <= hidx_next;
            hstart_reg <= hstart_next;
            hsum_reg   <= hsum_next;
            horig_reg  <= horig_next;
            hdecl_reg  <= hdecl_next;
            left_reg   <= left_next;
            pads_reg   <= pads_next;
            blocks_reg <= blocks_next;
            ferr_reg   <= ferr_next;
        end
    end

    // two-entry output buffer, q0 is the head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q0v_reg <= 1'b0;
            q1v_reg <= 1'b0;
        end else begin
            if (out_pop && push) begin
                if (q1v_reg) begin
                    q0_reg <= q1_reg;
                    q1_reg <= res;
                end else begin
                    q0_reg <= res;
                end
            end else if (out_pop) begin
                q0_reg  <= q1_reg;
                q0v_reg <= q1v_reg;
                q1v_reg <= 1'b0;
            end else if (push) begin
                if (!q0v_reg) begin
                    q0_reg  <= res;
                    q0v_reg <= 1'b1;
                end else begin
                    q1_reg  <= res;
                    q1v_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = q0v_reg;
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.last;
    assign m_tdata  = {5'b00000, q0_reg.status, q0_reg.sum_field, q0_reg.payload_size,
                       q0_reg.original_size, q0_reg.block_offset, q0_reg.block_number};

endmodule

/* dv/block_chain_validator_test.sv */
// self-checking testbench for the block chain validator: random containers, scoreboard
`timescale 1ns / 1ps

module block_chain_validator_test;

    localparam logic [31:0] MAGIC_WORD   = 32'h4d493130;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          SUM_SAFE_MAX = 16843008;   // largest size with size*255+255 in 32 bits

    typedef struct packed {
        logic [7:0] data;
        logic       eoc;
    } cbyte_t;

    typedef enum logic [2:0] {W_HEADER, W_MARKER, W_PAYLOAD, W_GAP, W_SINK} walk_t;

    typedef enum int {
        F_NONE, F_MAGIC, F_ALIGN, F_ZERO, F_LARGE, F_SUM, F_MARKER, F_TRUNC, F_PADS, F_HUGE,
        F_NOISE
    } fault_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bcv_pkg::M_DATA_W-1:0]    m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bcv_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bcv_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    block_chain_validator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cbyte_t           container_bytes_q[$];
    bcv_pkg::result_t chain_reports_q[$];
    logic [7:0]       frame_q[$];
    int               errors  = 0;
    bit               gaps_on = 1'b1;

    // chain walker state and register copies
    logic [bcv_pkg::LIMIT_W-1:0]     limit_reg;
    logic [bcv_pkg::OFFSET_BITS-1:0] base_reg;
    walk_t                           walk;
    logic [bcv_pkg::OFFSET_BITS-1:0] byte_pos;
    logic [bcv_pkg::IDX_W-1:0]       hdr_idx;
    logic [bcv_pkg::OFFSET_BITS-1:0] hdr_start;
    logic [31:0]                     h_sum;
    logic [31:0]                     h_orig;
    logic [31:0]                     h_decl;
    logic [31:0]                     pay_left;
    logic [bcv_pkg::PADS_W-1:0]      pads;
    logic [bcv_pkg::LIMIT_W-1:0]     blocks_done;
    logic [bcv_pkg::STATUS_W-1:0]    first_err;

    function automatic void clear_chain();
        walk        = W_HEADER;
        byte_pos    = '0;
        hdr_idx     = '0;
        hdr_start   = '0;
        h_sum       = '0;
        h_orig      = '0;
        h_decl      = '0;
        pay_left    = '0;
        pads        = '0;
        blocks_done = '0;
        first_err   = bcv_pkg::ST_OK;
    endfunction

    function automatic void trip(input logic [bcv_pkg::STATUS_W-1:0] code);
        first_err = code;
        walk      = W_SINK;
    endfunction

    function automatic void open_header(input logic [bcv_pkg::OFFSET_BITS-1:0] at);
        walk      = W_HEADER;
        hdr_idx   = '0;
        hdr_start = at;
        h_sum     = '0;
        h_orig    = '0;
        h_decl    = '0;
        if (at[0]) begin
            trip(bcv_pkg::ST_ALIGN);
        end else if (blocks_done >= limit_reg) begin
            trip(bcv_pkg::ST_MANY);
        end
    endfunction

    function automatic void take_header_byte(input logic [7:0] b);
        logic [bcv_pkg::IDX_W-1:0] i;
        i = hdr_idx;
        if (i < 4) begin
            if (b != MAGIC_WORD[8*(3-i[1:0]) +: 8]) begin
                trip(bcv_pkg::ST_MAGIC);
                return;
            end
        end else if (i < 8) begin
            h_sum = {h_sum[23:0], b};
        end else if (i < 12) begin
            h_orig = {h_orig[23:0], b};
        end else begin
            h_decl = {h_decl[23:0], b};
        end
        hdr_idx = i + 1'b1;
        if (i != bcv_pkg::HDR_LAST) return;
        if (h_orig == 0 || h_decl == 0) begin
            trip(bcv_pkg::ST_ZERO);
        end else if (h_orig > bcv_pkg::ORIG_CAP || h_decl > bcv_pkg::DECL_CAP) begin
            trip(bcv_pkg::ST_LARGE);
        end else if ({32'd0, h_sum} > {32'd0, h_orig} * 64'd255) begin
            trip(bcv_pkg::ST_SUM);
        end else begin
            walk = W_MARKER;
        end
    endfunction

    // advance the chain walker by one container byte, queue any report it yields
    function automatic void walk_chain_byte(input logic [7:0] b, input logic eoc);
        logic [bcv_pkg::OFFSET_BITS-1:0] at;
        logic                            emit;
        logic [bcv_pkg::LIMIT_W-1:0]     count;
        logic [bcv_pkg::STATUS_W-1:0]    st;
        bcv_pkg::result_t                r;
        at   = byte_pos;
        emit = 1'b0;
        case (walk)
            W_HEADER: begin
                if (hdr_idx == 0) open_header(at);
                if (walk == W_HEADER) take_header_byte(b);
            end
            W_MARKER: begin
                if (b != 8'h00) begin
                    trip(bcv_pkg::ST_MARKER);
                end else begin
                    blocks_done = blocks_done + 1'b1;
                    pay_left    = h_decl + 1;
                    walk        = W_PAYLOAD;
                    emit        = 1'b1;
                end
            end
            W_PAYLOAD: begin
                pay_left = pay_left - 1;
                if (pay_left == 0) begin
                    walk = W_GAP;
                    pads = '0;
                end
            end
            W_GAP: begin
                if (b == bcv_pkg::PAD_VALUE && pads < bcv_pkg::PAD_MAX) begin
                    pads = pads + 1'b1;
                end else begin
                    open_header(at);
                    if (walk == W_HEADER) take_header_byte(b);
                end
            end
            default: ;
        endcase
        byte_pos = byte_pos + 1'b1;

        r = '0;
        if (!eoc) begin
            if (emit) begin
                r.kind          = bcv_pkg::KIND_DESC;
                r.block_number  = blocks_done;
                r.block_offset  = base_reg + hdr_start;
                r.original_size = h_orig[bcv_pkg::SIZE_W-1:0];
                r.payload_size  = bcv_pkg::SIZE_W'(h_decl + 2);
                r.sum_field     = h_sum;
                chain_reports_q.push_back(r);
            end
        end else begin
            st    = first_err;
            count = blocks_done;
            if (st == bcv_pkg::ST_OK) begin
                // a block cut inside its payload does not count
                if (walk == W_PAYLOAD) begin
                    st    = bcv_pkg::ST_TRUNC;
                    count = count - 1'b1;
                end else if (walk != W_GAP) begin
                    st = bcv_pkg::ST_TRUNC;
                end
            end
            r.kind         = bcv_pkg::KIND_VERDICT;
            r.last         = 1'b1;
            r.status       = st;
            r.block_number = count;
            chain_reports_q.push_back(r);
            clear_chain();
        end
    endfunction

    // ---------------- container generation ----------------

    function automatic void put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) frame_q.push_back(w[8*k +: 8]);
    endfunction

    function automatic void add_block(input fault_t fault);
        logic [31:0] orig;
        logic [31:0] decl;
        logic [31:0] sum;
        logic [31:0] flip;
        logic [63:0] bound;
        int          n;
        case ($urandom_range(0, 5))
            0:       orig = 32'd1;
            1:       orig = bcv_pkg::ORIG_CAP;
            default: orig = $urandom_range(1, bcv_pkg::ORIG_CAP);
        endcase
        if (fault == F_SUM) orig = $urandom_range(1, SUM_SAFE_MAX);
        decl  = $urandom_range(1, 12);
        bound = 64'(orig) * 64'd255;
        if (bound >= 64'hffff_ffff) begin
            sum = $urandom;
        end else if ($urandom_range(0, 3) == 0) begin
            sum = bound[31:0];
        end else begin
            sum = $urandom_range(0, bound[31:0]);
        end
        flip = '0;
        case (fault)
            F_MAGIC:  flip = 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
            F_ZERO:   if ($urandom_range(0, 1)) orig = '0; else decl = '0;
            F_LARGE: begin
                if ($urandom_range(0, 1)) begin
                    orig = $urandom_range(32'h8000_0000, 32'hffff_ffff);
                end else begin
                    decl = $urandom_range(32'h7fff_fffe, 32'hffff_ffff);
                end
            end
            F_SUM:    sum  = bound[31:0] + $urandom_range(1, 255);
            F_HUGE:   decl = $urandom_range(13, bcv_pkg::DECL_CAP);
            default: ;
        endcase
        put_word(MAGIC_WORD ^ flip);
        put_word(sum);
        put_word(orig);
        put_word(decl);
        frame_q.push_back(fault == F_MARKER ? 8'($urandom_range(1, 255)) : 8'h00);
        if (fault == F_HUGE || decl == 0 || decl > 12) n = $urandom_range(0, 3);
        else n = decl + 1;
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    function automatic void build_container(input fault_t fault);
        int nblk;
        int fb;
        int npad;
        int cut;
        frame_q.delete();
        if (fault == F_NOISE) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
            return;
        end
        nblk = (fault == F_ALIGN || fault == F_PADS) ? $urandom_range(2, 4)
                                                     : $urandom_range(1, 4);
        fb   = (fault == F_ALIGN || fault == F_PADS) ? $urandom_range(1, nblk - 1)
                                                     : $urandom_range(0, nblk - 1);
        // an unfinishable block can only be the last one
        if (fault == F_HUGE) fb = nblk - 1;
        for (int k = 0; k < nblk; k++) begin
            if (k > 0) begin
                if (k == fb && fault == F_ALIGN) npad = (frame_q.size() % 2) ? 0 : 1;
                else if (k == fb && fault == F_PADS) npad = 3;
                else npad = (frame_q.size() % 2) ? 1 : 2 * $urandom_range(0, 1);
                repeat (npad) frame_q.push_back(bcv_pkg::PAD_VALUE);
            end
            add_block(k == fb ? fault : F_NONE);
        end
        if (fault == F_NONE) begin
            repeat ($urandom_range(0, 2)) frame_q.push_back(bcv_pkg::PAD_VALUE);
        end
        if (fault == F_TRUNC) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endfunction

    function automatic int queue_frame();
        cbyte_t c;
        foreach (frame_q[k]) begin
            c.data = frame_q[k];
            c.eoc  = (k == frame_q.size() - 1);
            container_bytes_q.push_back(c);
        end
        return frame_q.size();
    endfunction

    task automatic fill_containers(input int nbytes);
        int     total;
        int     f;
        fault_t fault;
        total = 0;
        while (total < nbytes) begin
            f     = $urandom_range(0, 18);
            fault = (f < 9) ? F_NONE : fault_t'(f - 8);
            build_container(fault);
            total += queue_frame();
        end
    endtask

    task automatic drain();
        while (container_bytes_q.size() != 0 || s_tvalid || chain_reports_q.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [bcv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcv_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bcv_pkg::CFG_BLOCK_LIMIT) limit_reg = val[bcv_pkg::LIMIT_W-1:0];
        else if (idx == bcv_pkg::CFG_BASE_OFFSET) base_reg = val[bcv_pkg::OFFSET_BITS-1:0];
    endtask

    // ---------------- byte driver ----------------

    int     send_gap = 0;
    cbyte_t next_byte;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) walk_chain_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (container_bytes_q.size() > 0) begin
                    next_byte = container_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tlast  <= next_byte.eoc;
                    if (gaps_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- report monitor ----------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    int               hold_left = 0;
    bcv_pkg::result_t seen;
    bcv_pkg::result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tuser, m_tlast, m_tdata[bcv_pkg::M_DATA_W-6:0]};
                if (chain_reports_q.size() == 0) begin
                    $display("%0t unexpected transaction: expected none, actual %h", $time, seen);
                    errors++;
                end else begin
                    want = chain_reports_q.pop_front();
                    check_field("result_kind", 64'(want.kind), 64'(seen.kind));
                    check_field("block_number", 64'(want.block_number), 64'(seen.block_number));
                    check_field("block_offset", 64'(want.block_offset),
                                64'(seen.block_offset));
                    check_field("original_size", 64'(want.original_size),
                                64'(seen.original_size));
                    check_field("payload_size", 64'(want.payload_size), 64'(seen.payload_size));
                    check_field("sum_field", 64'(want.sum_field), 64'(seen.sum_field));
                    check_field("status", 64'(want.status), 64'(seen.status));
                    check_field("last_result", 64'(want.last), 64'(seen.last));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 11) == 0) hold_left = $urandom_range(1, 17);
            end
        end
    end

    // ---------------- watchdog ----------------

    int quiet = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("[block_chain_validator] ERROR");
                    $finish;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        limit_reg = bcv_pkg::BLOCK_LIMIT_RESET;
        base_reg  = '0;
        clear_chain();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // single-byte containers: wrong magic, all-ones, cut inside the magic
        frame_q = '{8'h00};
        void'(queue_frame());
        frame_q = '{8'hff};
        void'(queue_frame());
        frame_q = '{8'h4d};
        void'(queue_frame());
        // one minimal block with the widest header values
        frame_q.delete();
        put_word(MAGIC_WORD);
        put_word(32'hffff_ffff);
        put_word(bcv_pkg::ORIG_CAP);
        put_word(32'd1);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hff);
        frame_q.push_back(bcv_pkg::PAD_VALUE);
        void'(queue_frame());
        drain();

        cfg_write(bcv_pkg::CFG_BLOCK_LIMIT, bcv_pkg::CFG_DATA_W'(bcv_pkg::BLOCK_LIMIT_RESET));
        cfg_write(bcv_pkg::CFG_BASE_OFFSET, {bcv_pkg::CFG_DATA_W{1'b1}});
        fill_containers(150);
        drain();

        // runaway limit of one block
        cfg_write(bcv_pkg::CFG_BLOCK_LIMIT, bcv_pkg::CFG_DATA_W'(1));
        cfg_write(bcv_pkg::CFG_BASE_OFFSET, '0);
        fill_containers(110);
        drain();

        cfg_write(bcv_pkg::CFG_BLOCK_LIMIT, bcv_pkg::CFG_DATA_W'($urandom_range(2, 4)));
        cfg_write(bcv_pkg::CFG_BASE_OFFSET, bcv_pkg::CFG_DATA_W'({$urandom, $urandom}));
        fill_containers(150);
        drain();

        // closing stretch at full rate
        gaps_on = 1'b0;
        cfg_write(bcv_pkg::CFG_BLOCK_LIMIT, bcv_pkg::CFG_DATA_W'(bcv_pkg::BLOCK_LIMIT_RESET));
        cfg_write(bcv_pkg::CFG_BASE_OFFSET, bcv_pkg::CFG_DATA_W'({$urandom, $urandom}));
        fill_containers(170);
        drain();
        repeat (10) @(posedge aclk);

        if (errors == 0) begin
            $display("[block_chain_validator] OK");
        end else begin
            $display("[block_chain_validator] ERROR");
        end
        $finish;
    end

endmodule
